FILE: hdl/wtbg_pkg.sv
package wtbg_pkg;

	// Fixed sizes of the tone generator
	localparam int PHASE_BITS  = 32;
	localparam int TABLE_BITS  = 10;
	localparam int INDEX_SHIFT = PHASE_BITS - TABLE_BITS - 2;
	localparam int QUARTER     = 1 << TABLE_BITS;
	localparam int QTAB_SIZE   = QUARTER + 1;
	localparam int QTAB_AW     = TABLE_BITS + 1;
	localparam int AMP_W       = 15;
	localparam int SAMP_W      = 16;
	localparam int DUR_W       = 10;
	localparam int FREQ_W      = 31;
	localparam int CNT_W       = 16;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Duration to sample count: n = (dur * 441) / 10, division by reciprocal
	localparam int SR_PER_10MS = 441;
	localparam int RECIP_10    = 838861;   // ceil(2^23 / 10)
	localparam int RECIP_SHIFT = 23;

	localparam logic [AMP_W-1:0] AMP_RESET = 15'd3932;
	localparam logic [PHASE_BITS-1:0] QUARTER_CYCLE = 32'h4000_0000;

	// Divider runs over a PHASE_BITS+1 bit dividend (2^PHASE_BITS)
	localparam int DIV_N_W   = PHASE_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	typedef logic [AMP_W-1:0] qtab_t [QTAB_SIZE];

	typedef struct packed {
		logic              kind;
		logic [FREQ_W-1:0] freq_step;
		logic [DUR_W-1:0]  duration_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample;
		logic                     active;
		logic                     last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_N1,
		ST_N2,
		ST_N3,
		ST_DIV,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_T5,
		ST_EMIT
	} state_t;

	// Scale down by 2^30, rounding toward zero
	function automatic longint q30_trunc(input longint a);
		return (a < 0) ? -((-a) >>> 30) : (a >>> 30);
	endfunction

	// Long division of a signed value by a small positive constant, toward zero
	function automatic longint small_trunc_div(input longint num, input longint den);
		logic [63:0] mag;
		logic [63:0] d;
		logic [63:0] rem;
		logic [63:0] quo;
		int          b;
		mag = (num < 0) ? 64'(-num) : 64'(num);
		d   = 64'(den);
		rem = '0;
		quo = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[62:0], mag[b]};
			if (rem >= d) begin
				rem    = rem - d;
				quo[b] = 1'b1;
			end
		end
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	// Quarter-wave sine table, integer Taylor series with Q30 intermediates
	function automatic qtab_t build_qtab();
		qtab_t  tab;
		longint x;
		longint term;
		longint sum;
		longint v;
		longint q30;
		longint half_pi;
		int     k;
		int     i;
		q30     = longint'(1) << 30;
		half_pi = 64'sd1686629713;
		for (k = 0; k < QTAB_SIZE; k++) begin
			x    = (longint'(k) * half_pi) >>> TABLE_BITS;
			term = x;
			sum  = x;
			for (i = 1; i <= 7; i++) begin
				term = q30_trunc(term * x);
				term = q30_trunc(term * x);
				term = small_trunc_div(-term, longint'((2 * i) * (2 * i + 1)));
				sum  = sum + term;
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = q30_trunc(sum * 32767 + (q30 >>> 1));
			if (v > 32767) begin
				v = 32767;
			end
			tab[k] = v[AMP_W-1:0];
		end
		return tab;
	endfunction

	// Table address for a phase index: mirror in odd quadrants
	function automatic logic [QTAB_AW-1:0] qtab_addr(input logic [TABLE_BITS+1:0] j);
		logic [QTAB_AW-1:0] r;
		r = {1'b0, j[TABLE_BITS-1:0]};
		return j[TABLE_BITS] ? (QTAB_AW'(QUARTER) - r) : r;
	endfunction

endpackage

FILE: hdl/wtbg_rom.sv
module wtbg_rom
	import wtbg_pkg::*;
(
	input  logic               clk,
	input  logic [QTAB_AW-1:0] addr,
	output logic [AMP_W-1:0]   data
);

	localparam qtab_t QTAB = build_qtab();

	logic [AMP_W-1:0] data_q;

	// Registered table read
	always_ff @(posedge clk) begin
		data_q <= QTAB[addr];
	end

	assign data = data_q;

endmodule

FILE: hdl/wtbg_mul.sv
module wtbg_mul
	import wtbg_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p
);

	logic signed [MUL_P_W-1:0] p_q;

	// One signed product per cycle, registered
	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

FILE: hdl/wtbg_div.sv
module wtbg_div
	import wtbg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CNT_W-1:0]      divisor,
	output logic                  done,
	output logic [PHASE_BITS-1:0] quotient
);

	logic                 running_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_N_W-1:0]   quo_q;
	logic [CNT_W+1:0]     diff;
	logic                 ge;

	// Restoring step: one quotient bit per cycle
	assign diff = {1'b0, rem_q, quo_q[DIV_N_W-1]} - {2'b00, dvs_q};
	assign ge   = ~diff[CNT_W+1];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= DIV_CNT_W'(DIV_N_W);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend is 2^PHASE_BITS
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= {1'b1, {PHASE_BITS{1'b0}}};
		end else if (running_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[DIV_N_W-1]};
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[PHASE_BITS-1:0];

endmodule

FILE: hdl/windowed_tone_burst_generator_core.sv
// Tick in a burst: T1 to T5 register the result, EMIT moves it into the output register,
// then the next item is taken. Idle tick: EMIT moves a zero result, then the next item.
// Start: no result; N1 and N2 form the sample count (2 multiplier passes), N3 starts the
// 33-step divider and DIV waits for it, or N3 returns to idle for fewer than two samples.
// The output register decouples the sides: a new item is taken while a result waits.
// Reset (arst_n low): idle, no burst, amplitude 3932, output register empty.
module windowed_tone_burst_generator_core
	import wtbg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [AMP_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data
);

	state_t state_q, state_d;

	logic [AMP_W-1:0]      amplitude_q;
	logic [PHASE_BITS-1:0] sine_phase_q;
	logic [PHASE_BITS-1:0] env_phase_q;
	logic [PHASE_BITS-1:0] env_step_q;
	logic [PHASE_BITS-1:0] tone_step_q;
	logic [CNT_W-1:0]      samples_left_q;
	logic                  busy_q;
	logic [DUR_W-1:0]      dur_q;
	logic [1:0]            quad_q;
	logic signed [SAMP_W-1:0] s_q;

	logic signed [SAMP_W-1:0] res_sample_q;
	logic                     res_last_q;
	logic                     res_active_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic [QTAB_AW-1:0]        rom_addr;
	logic [AMP_W-1:0]          rom_data;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic                      div_start;
	logic                      div_done;
	logic [PHASE_BITS-1:0]     div_quo;

	logic                      in_fire;
	logic                      emit_go;
	logic [CNT_W-1:0]          n_samples;
	logic [PHASE_BITS-1:0]     cos_phase;
	logic signed [SAMP_W-1:0]  tab_signed;
	logic signed [SAMP_W:0]    env_full;
	logic signed [MUL_P_W-1:0] prod_bias;
	logic signed [MUL_P_W-1:0] prod_shift;

	assign in_fire   = in_valid && in_ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign n_samples = mul_p[RECIP_SHIFT+CNT_W-1:RECIP_SHIFT];
	assign cos_phase = env_phase_q + QUARTER_CYCLE;

	// Table value with the sign of the latched quadrant
	assign tab_signed = quad_q[1] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
	assign env_full   = $signed(17'sd32767) - $signed({tab_signed[SAMP_W-1], tab_signed});

	// Truncate the Q30 product toward zero
	assign prod_bias  = mul_p + (mul_p[MUL_P_W-1] ? MUL_P_W'((64'd1 << 30) - 64'd1) : '0);
	assign prod_shift = prod_bias >>> 30;

	wtbg_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	wtbg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	wtbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (n_samples - 1'b1),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.kind) begin
						state_d = ST_N1;
					end else if (busy_q) begin
						state_d = ST_T1;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_N1: state_d = ST_N2;
			ST_N2: state_d = ST_N3;
			ST_N3: begin
				state_d = (n_samples >= CNT_W'(2)) ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_T1: state_d = ST_T2;
			ST_T2: state_d = ST_T3;
			ST_T3: state_d = ST_T4;
			ST_T4: state_d = ST_T5;
			ST_T5: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: input ready, divider start, shared unit operands and table address
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		rom_addr  = qtab_addr(sine_phase_q[PHASE_BITS-1:INDEX_SHIFT]);
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_N1: begin
				mul_a = MUL_A_W'(dur_q);
				mul_b = MUL_B_W'(SR_PER_10MS);
			end
			ST_N2: begin
				mul_a = MUL_A_W'(mul_p[19:0]);
				mul_b = MUL_B_W'(RECIP_10);
			end
			ST_N3: div_start = (n_samples >= CNT_W'(2));
			ST_T2: rom_addr = qtab_addr(cos_phase[PHASE_BITS-1:INDEX_SHIFT]);
			ST_T3: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(env_full[AMP_W:1]);
			end
			ST_T4: begin
				mul_a = mul_p[MUL_A_W-1:0];
				mul_b = MUL_B_W'(amplitude_q);
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			amplitude_q    <= AMP_RESET;
			busy_q         <= 1'b0;
			samples_left_q <= '0;
			sine_phase_q   <= '0;
			env_phase_q    <= '0;
			env_step_q     <= '0;
			tone_step_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				amplitude_q <= cfg_wdata;
			end
			if (in_fire && in_data.kind) begin
				tone_step_q  <= PHASE_BITS'(in_data.freq_step);
				sine_phase_q <= '0;
				env_phase_q  <= '0;
			end
			if (state_q == ST_N3) begin
				samples_left_q <= n_samples;
				env_step_q     <= '0;
				busy_q         <= (n_samples != '0);
			end
			if (state_q == ST_DIV && div_done) begin
				env_step_q <= div_quo;
			end
			if (state_q == ST_T5) begin
				sine_phase_q   <= sine_phase_q + tone_step_q;
				env_phase_q    <= env_phase_q + env_step_q;
				samples_left_q <= samples_left_q - 1'b1;
				if (samples_left_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dur_q        <= in_data.duration_ms;
			res_sample_q <= '0;
			res_active_q <= 1'b0;
			res_last_q   <= 1'b0;
		end
		if (state_q == ST_T1) begin
			quad_q <= sine_phase_q[PHASE_BITS-1:PHASE_BITS-2];
		end
		if (state_q == ST_T2) begin
			s_q    <= tab_signed;
			quad_q <= cos_phase[PHASE_BITS-1:PHASE_BITS-2];
		end
		if (state_q == ST_T5) begin
			res_sample_q <= prod_shift[SAMP_W-1:0];
			res_active_q <= 1'b1;
			res_last_q   <= (samples_left_q == CNT_W'(1));
		end
		if (emit_go) begin
			out_q.sample <= res_sample_q;
			out_q.active <= res_active_q;
			out_q.last   <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// An idle transaction carries a zero sample and no last mark
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.active |-> out_data.sample == '0 && !out_data.last)
		else $error("idle result not zero");

	// Last is only marked on an active sample
	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.active)
		else $error("last without active");

	// A burst ends only on its last sample or on a zero-length start
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> res_last_q || state_q == ST_IDLE)
		else $error("burst ended without last sample");

	// Divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider result outside divide phase");

endmodule

FILE: dv/tb_windowed_tone_burst_generator_core.sv
`timescale 1ns / 100ps

module tb_windowed_tone_burst_generator_core
	import wtbg_pkg::*;
();

	localparam int     SAMPLE_RATE_HZ = 44100;
	localparam int     FULL_SCALE     = 32767;
	localparam longint Q30_ONE        = 64'sd1 << 30;
	localparam longint HALF_PI_Q30    = 64'sd1686629713;
	localparam logic   KIND_TICK      = 1'b0;
	localparam logic   KIND_START     = 1'b1;
	localparam int     SETTLE_CYCLES  = 60;    // lets a start item finish; it yields no result
	localparam int     RANDOM_PHASES  = 6;
	localparam int     PHASE_ITEMS    = 80;
	localparam int     HOLD_CYCLES    = 400;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [AMP_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;

	// Predicted generator state
	logic [AMP_W-1:0]      amp_q15       = AMP_RESET;
	logic [PHASE_BITS-1:0] tone_inc      = '0;
	logic [PHASE_BITS-1:0] tone_ph       = '0;
	logic [PHASE_BITS-1:0] env_inc       = '0;
	logic [PHASE_BITS-1:0] env_ph        = '0;
	logic [CNT_W-1:0]      samples_to_go = '0;
	logic                  burst_on      = 1'b0;
	logic [AMP_W-1:0]      sine_tab [QTAB_SIZE];

	in_item_t  pending_items[$];
	out_item_t expected_samples[$];

	// Handshake bookkeeping; in_sent, pauses_on and hold_request are shared between processes
	logic        in_sent       = 1'b0;
	logic        pauses_on     = 1'b1;
	logic        hold_request  = 1'b0;
	int unsigned send_gap      = 0;
	int unsigned ready_gap     = 0;
	int unsigned hold_left     = 0;

	int unsigned fail_count    = 0;
	int unsigned items_queued  = 0;
	int unsigned n_starts      = 0;
	int unsigned n_ticks       = 0;
	int unsigned n_burst_out   = 0;
	int unsigned n_last_out    = 0;
	int unsigned n_idle_out    = 0;
	int unsigned amp_writes    = 0;

	windowed_tone_burst_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Quarter-wave sine table: Taylor series in Q30, rounded to Q15 magnitude
	initial begin : build_sine_table
		longint x;
		longint term;
		longint acc;
		longint v;
		int     k;
		int     i;
		for (k = 0; k < QTAB_SIZE; k++) begin
			x    = (longint'(k) * HALF_PI_Q30) >>> TABLE_BITS;
			term = x;
			acc  = x;
			for (i = 1; i <= 7; i++) begin
				term = term * x / Q30_ONE;
				term = term * x / Q30_ONE;
				term = -term / longint'(2 * i * (2 * i + 1));
				acc  = acc + term;
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (acc * FULL_SCALE + Q30_ONE / 2) / Q30_ONE;
			if (v > FULL_SCALE) begin
				v = FULL_SCALE;
			end
			sine_tab[k] = v[AMP_W-1:0];
		end
	end

	// Signed sine of a phase: top bits pick quadrant, odd quadrants mirror
	function automatic int sine_lookup(input logic [PHASE_BITS-1:0] ph);
		logic [TABLE_BITS+1:0] j;
		logic [QTAB_AW-1:0]    r;
		logic [QTAB_AW-1:0]    idx;
		int                    mag;
		j   = ph[PHASE_BITS-1 -: TABLE_BITS+2];
		r   = {1'b0, j[TABLE_BITS-1:0]};
		idx = j[TABLE_BITS] ? (QTAB_AW'(QUARTER) - r) : r;
		mag = int'(sine_tab[idx]);
		return j[TABLE_BITS+1] ? -mag : mag;
	endfunction

	// Burst sample predictor: start reloads the burst, tick yields one sample
	task automatic predict_burst_sample(input in_item_t it);
		int unsigned n;
		logic [63:0] step64;
		int          s;
		int          c;
		int          env;
		longint      prod;
		longint      smp;
		out_item_t   r;
		if (it.kind == KIND_START) begin
			n_starts++;
			n        = (SAMPLE_RATE_HZ * int'(it.duration_ms)) / 1000;
			tone_inc = {1'b0, it.freq_step};
			tone_ph  = '0;
			env_ph   = '0;
			if (n >= 2) begin
				step64  = (64'd1 << PHASE_BITS) / 64'(n - 1);
				env_inc = step64[PHASE_BITS-1:0];
			end else begin
				env_inc = '0;
			end
			samples_to_go = n[CNT_W-1:0];
			burst_on      = (samples_to_go != 0);
		end else begin
			n_ticks++;
			r = '0;
			if (burst_on) begin
				s        = sine_lookup(tone_ph);
				c        = sine_lookup(env_ph + QUARTER_CYCLE);
				env      = (FULL_SCALE - c) / 2;
				prod     = longint'(s) * longint'(env) * longint'(amp_q15);
				smp      = prod / Q30_ONE;    // truncates toward zero
				r.sample = smp[SAMP_W-1:0];
				r.active = 1'b1;
				r.last   = (samples_to_go == 1);
				tone_ph  = tone_ph + tone_inc;
				env_ph   = env_ph + env_inc;
				samples_to_go = samples_to_go - 1'b1;
				if (samples_to_go == 0) begin
					burst_on = 1'b0;
				end
			end
			expected_samples.push_back(r);
		end
	endtask

	// Mostly back to back, some short pauses, a few long ones
	function automatic int unsigned random_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_item(input logic kind, input logic [FREQ_W-1:0] f,
			input logic [DUR_W-1:0] d);
		in_item_t it;
		it.kind        = kind;
		it.freq_step   = f;
		it.duration_ms = d;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// One start followed by ticks: run to the end plus idle ticks, or cut short
	task automatic queue_burst();
		int unsigned       sel;
		int unsigned       dur;
		int unsigned       nsamp;
		int unsigned       nticks;
		int unsigned       k;
		logic [FREQ_W-1:0] f;
		sel = $urandom_range(0, 15);
		if (sel < 8) begin
			dur = 1;
		end else if (sel < 10) begin
			dur = 2;
		end else if (sel < 11) begin
			dur = 3;
		end else if (sel < 12) begin
			dur = 0;
		end else begin
			dur = $urandom_range(4, 1023);
		end
		case ($urandom_range(0, 7))
			0: begin
				f = '0;
			end
			1: begin
				f = '1;
			end
			2: begin
				f = FREQ_W'($urandom_range(1, 1 << 20));
			end
			default: begin
				f = FREQ_W'($urandom());
			end
		endcase
		nsamp = SAMPLE_RATE_HZ * dur / 1000;
		if (nsamp > 200 || $urandom_range(0, 3) == 0) begin
			nticks = $urandom_range(0, 40);
		end else begin
			nticks = nsamp + $urandom_range(0, 3);
		end
		queue_item(KIND_START, f, dur[DUR_W-1:0]);
		for (k = 0; k < nticks; k++) begin
			queue_item(KIND_TICK, FREQ_W'($urandom()), DUR_W'($urandom()));
		end
	endtask

	task automatic write_amplitude(input logic [AMP_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		amp_writes++;
	endtask

	// Wait for every item to be taken and every result to arrive, then let a start finish
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_sent) begin
			in_sent = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				in_data  <= pending_items.pop_front();
				in_valid <= 1'b1;
				send_gap = pauses_on ? random_pause() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure, with one long hold on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (!pauses_on) begin
			out_ready <= 1'b1;
		end else if (ready_gap > 0) begin
			ready_gap--;
			out_ready <= 1'b0;
		end else begin
			ready_gap = random_pause();
			out_ready <= 1'b1;
		end
	end

	// Monitor: register writes, result check, prediction on each input transaction
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				amp_q15 = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (out_data.active) begin
					n_burst_out++;
				end else begin
					n_idle_out++;
				end
				if (out_data.last) begin
					n_last_out++;
				end
				if (expected_samples.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, got sample=%0d active=%0b last=%0b",
						$realtime, out_data.sample, out_data.active, out_data.last);
				end else begin
					want = expected_samples.pop_front();
					if (out_data.sample !== want.sample || out_data.active !== want.active ||
							out_data.last !== want.last) begin
						fail_count++;
						$display("%0t: mismatch: expected sample=%0d active=%0b last=%0b, got sample=%0d active=%0b last=%0b",
							$realtime, want.sample, want.active, want.last,
							out_data.sample, out_data.active, out_data.last);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_burst_sample(in_data);
				in_sent = 1'b1;
			end
		end
	end

	// Stimulus sequence
	initial begin : stimulus
		int                 p;
		int unsigned        phase_start;
		logic [AMP_W-1:0]   amp_val;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, zero-length burst, field extremes, restarts mid-burst
		queue_item(KIND_TICK, '1, '1);
		queue_item(KIND_START, '0, '0);
		queue_item(KIND_TICK, '0, '0);
		queue_item(KIND_START, '1, '1);
		repeat (4) queue_item(KIND_TICK, '0, '1);
		queue_item(KIND_START, 31'h1000_0000, 10'd1);
		repeat (5) queue_item(KIND_TICK, '1, '0);
		queue_item(KIND_START, '0, 10'd2);
		repeat (3) queue_item(KIND_TICK, '0, '0);
		queue_item(KIND_START, 31'd1, 10'd1);
		repeat (3) queue_item(KIND_TICK, '1, '1);
		drain();

		// Random bursts, one amplitude per phase
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					amp_val = 15'd32767;
				end
				1: begin
					amp_val = 15'd0;
				end
				2: begin
					amp_val = 15'd1;
				end
				5: begin
					amp_val = 15'd32767;
				end
				default: begin
					amp_val = AMP_W'($urandom_range(2, 32766));
				end
			endcase
			write_amplitude(amp_val);
			pauses_on   = (p != 0);
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS) begin
				queue_burst();
			end
			// receiver stalls long while the sender keeps offering
			if (p == 3) begin
				hold_request = 1'b1;
			end
			drain();
		end

		$display("Run covered %0d burst starts and %0d ticks under %0d amplitude settings.",
			n_starts, n_ticks, amp_writes + 1);
		$display("Results: %0d burst samples, %0d marked last, %0d idle; %0d mismatches.",
			n_burst_out, n_last_out, n_idle_out, fail_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#(5_000_000);
		$display("%0t: timeout with %0d items unsent and %0d results outstanding",
			$realtime, pending_items.size(), expected_samples.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: windowed_tone_burst_generator_core.f
hdl/wtbg_pkg.sv
hdl/wtbg_rom.sv
hdl/wtbg_mul.sv
hdl/wtbg_div.sv
hdl/windowed_tone_burst_generator_core.sv
dv/tb_windowed_tone_burst_generator_core.sv
